// ===== rtl/adsr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared types, widths and constants of the ADSR envelope / glide voice.
// ----------------------------------------------------------------------------
package adsr_pkg;

   localparam int LEVEL_W = 24;
   localparam int FREQ_W  = 23;
   localparam int GATE_W  = 20;
   localparam int COEF_W  = 16;
   localparam int GLEN_W  = 16;
   localparam int CSR_A_W = 3;

   localparam int MUL_A_W = 25;
   localparam int MUL_B_W = 18;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   localparam int DIVD_W  = 39;
   localparam int DIVS_W  = 16;
   localparam int QUOT_W  = 23;
   localparam int DCNT_W  = 5;

   localparam logic [LEVEL_W-1:0] FULL_SCALE = 24'd8388608;
   localparam logic [FREQ_W-1:0]  RESET_FREQ = 23'd112640;

   localparam logic [LEVEL_W-1:0] RST_ATTACK  = 24'd190;
   localparam logic [LEVEL_W-1:0] RST_DECAY   = 24'd190;
   localparam logic [LEVEL_W-1:0] RST_SUSTAIN = 24'd5033165;
   localparam logic [LEVEL_W-1:0] RST_RELEASE = 24'd95;
   localparam logic [COEF_W-1:0]  RST_COEFF   = 16'd64880;
   localparam logic [GLEN_W-1:0]  RST_GLEN    = 16'd2205;

   localparam logic [CSR_A_W-1:0] CSR_ATTACK  = 3'd0;
   localparam logic [CSR_A_W-1:0] CSR_DECAY   = 3'd1;
   localparam logic [CSR_A_W-1:0] CSR_SUSTAIN = 3'd2;
   localparam logic [CSR_A_W-1:0] CSR_RELEASE = 3'd3;
   localparam logic [CSR_A_W-1:0] CSR_COEFF   = 3'd4;
   localparam logic [CSR_A_W-1:0] CSR_GLEN    = 3'd5;

   typedef enum logic [2:0] {
      STG_IDLE    = 3'd0,
      STG_ATTACK  = 3'd1,
      STG_DECAY   = 3'd2,
      STG_SUSTAIN = 3'd3,
      STG_RELEASE = 3'd4
   } env_stage_type;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_GLIDE = 9'b000000010,
      S_GMUL  = 9'b000000100,
      S_GDIVS = 9'b000001000,
      S_GDIV  = 9'b000010000,
      S_ENV   = 9'b000100000,
      S_SM1   = 9'b001000000,
      S_SM2   = 9'b010000000,
      S_DONE  = 9'b100000000
   } seq_state_type;

endpackage
`default_nettype wire

// ===== rtl/adsr_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adsr_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module adsr_mul (
   input  wire logic                                 clock,
   input  wire logic signed [adsr_pkg::MUL_A_W-1:0]  op_a,
   input  wire logic signed [adsr_pkg::MUL_B_W-1:0]  op_b,
   output logic signed      [adsr_pkg::MUL_P_W-1:0]  prod
);

   logic signed [adsr_pkg::MUL_P_W-1:0] prod_ff;
   logic signed [adsr_pkg::MUL_P_W-1:0] prod_in;

   assign prod_in = adsr_pkg::MUL_P_W'(op_a) * adsr_pkg::MUL_P_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule
`default_nettype wire

// ===== rtl/adsr_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adsr_div
// Restoring divider, one quotient bit per cycle. The quotient must fit in
// QUOT_W bits, so the remainder starts from the dividend's upper bits.
// ----------------------------------------------------------------------------
module adsr_div (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [adsr_pkg::DIVD_W-1:0]     dividend,
   input  wire logic [adsr_pkg::DIVS_W-1:0]     divisor,
   output logic                                 done,
   output logic [adsr_pkg::QUOT_W-1:0]          quotient
);

   logic [adsr_pkg::DIVS_W-1:0] rem_ff, rem_in;
   logic [adsr_pkg::QUOT_W-1:0] quo_ff, quo_in;
   logic [adsr_pkg::DCNT_W-1:0] cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [adsr_pkg::DIVS_W:0]   trial;
   logic [adsr_pkg::DIVS_W:0]   diff;

   assign trial = {rem_ff, quo_ff[adsr_pkg::QUOT_W-1]};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend[adsr_pkg::DIVD_W-1:adsr_pkg::QUOT_W];
         quo_in  = dividend[adsr_pkg::QUOT_W-1:0];
         cnt_in  = adsr_pkg::DCNT_W'(adsr_pkg::QUOT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[adsr_pkg::DIVS_W]) begin
            rem_in = diff[adsr_pkg::DIVS_W-1:0];
            quo_in = {quo_ff[adsr_pkg::QUOT_W-2:0], 1'b1};
         end else begin
            rem_in = trial[adsr_pkg::DIVS_W-1:0];
            quo_in = {quo_ff[adsr_pkg::QUOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == adsr_pkg::DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// ===== rtl/adsr_envelope_gate_glide.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adsr_envelope_gate_glide
// One-voice linear ADSR envelope with gate timer, portamento and smoother.
// ----------------------------------------------------------------------------
// One transaction per audio sample, taken only while idle. Each passes the
// glide check, envelope step, both smoother products and commit; while a
// glide moves the frequency it adds the glide product and the 23-step serial
// divider that scales the glide move. One shared 25x18 multiplier serves the
// glide product and both smoother terms. The result register lets the next
// transaction be accepted while a response still waits. Configuration
// writes take effect on the next clock edge and are expected while idle.
// ----------------------------------------------------------------------------
module adsr_envelope_gate_glide (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_trigger,
   input  wire logic                              req_glide_request,
   input  wire logic [adsr_pkg::GATE_W-1:0]       req_gate_samples,
   input  wire logic [adsr_pkg::FREQ_W-1:0]       req_target_freq,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [adsr_pkg::LEVEL_W-1:0]           rsp_envelope,
   output logic [adsr_pkg::LEVEL_W-1:0]           rsp_smoothed_level,
   output logic [adsr_pkg::FREQ_W-1:0]            rsp_current_freq,
   output logic [2:0]                             rsp_stage,
   input  wire logic                              csr_we,
   input  wire logic [adsr_pkg::CSR_A_W-1:0]      csr_addr,
   input  wire logic [adsr_pkg::LEVEL_W-1:0]      csr_wdata
);

   localparam int LW = adsr_pkg::LEVEL_W;
   localparam int FW = adsr_pkg::FREQ_W;
   localparam int AW = adsr_pkg::MUL_A_W;
   localparam int BW = adsr_pkg::MUL_B_W;
   localparam int PW = adsr_pkg::MUL_P_W;
   localparam int SW = adsr_pkg::LEVEL_W + adsr_pkg::COEF_W + 2;

   // configuration
   logic [LW-1:0]                 attack_ff, decay_ff, sustain_ff, release_ff;
   logic [adsr_pkg::COEF_W-1:0]   coeff_ff;
   logic [adsr_pkg::GLEN_W-1:0]   glen_ff;

   // voice state
   adsr_pkg::seq_state_type       state_ff, state_in;
   adsr_pkg::env_stage_type       stage_ff, stage_in;
   logic [LW-1:0]                 env_ff, env_in;
   logic [LW-1:0]                 smooth_ff, smooth_in;
   logic [adsr_pkg::GATE_W-1:0]   gate_cnt_ff, gate_cnt_in;
   logic                          gate_open_ff, gate_open_in;
   logic [FW-1:0]                 freq_now_ff, freq_now_in;
   logic [FW-1:0]                 freq_goal_ff, freq_goal_in;
   logic [adsr_pkg::GLEN_W-1:0]   glide_cnt_ff, glide_cnt_in;
   logic                          glide_on_ff, glide_on_in;
   logic                          neg_ff, neg_in;
   logic [SW-1:0]                 acc_ff, acc_in;

   // response register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [LW-1:0]                 rsp_env_ff, rsp_smooth_ff;
   logic [FW-1:0]                 rsp_freq_ff;
   logic [2:0]                    rsp_stage_ff;
   logic                          rsp_load;

   // shared units
   logic signed [AW-1:0]          mul_a;
   logic signed [BW-1:0]          mul_b;
   logic signed [PW-1:0]          mul_p;
   logic [PW-1:0]                 mul_mag;
   logic                          div_start;
   logic                          div_done;
   logic [adsr_pkg::QUOT_W-1:0]   div_q;

   adsr_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_p)
   );

   assign mul_mag   = mul_p[PW-1] ? PW'(-mul_p) : PW'(mul_p);
   assign div_start = (state_ff == adsr_pkg::S_GDIVS);

   adsr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mul_mag[adsr_pkg::DIVD_W-1:0]),
      .divisor  (glen_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         adsr_pkg::S_GMUL: begin
            mul_a = signed'(AW'({2'b00, freq_goal_ff}) - AW'({2'b00, freq_now_ff}));
            mul_b = signed'(BW'({2'b00, glide_cnt_ff}));
         end
         adsr_pkg::S_SM1: begin
            mul_a = signed'({1'b0, smooth_ff});
            mul_b = signed'(BW'({2'b00, coeff_ff}));
         end
         adsr_pkg::S_SM2: begin
            mul_a = signed'({1'b0, env_ff});
            mul_b = signed'({1'b0, 17'h10000 - {1'b0, coeff_ff}});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign req_ready = (state_ff == adsr_pkg::S_IDLE);
   assign rsp_load  = (state_ff == adsr_pkg::S_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      logic [adsr_pkg::GLEN_W:0]  gcnt;
      logic [LW-1:0]              sus;
      logic [LW:0]                up;
      logic signed [LW+1:0]       dn;
      logic [LW:0]                move;
      logic [LW:0]                fsum;
      logic [SW-1:0]              ssum;

      state_in     = state_ff;
      stage_in     = stage_ff;
      env_in       = env_ff;
      smooth_in    = smooth_ff;
      gate_cnt_in  = gate_cnt_ff;
      gate_open_in = gate_open_ff;
      freq_now_in  = freq_now_ff;
      freq_goal_in = freq_goal_ff;
      glide_cnt_in = glide_cnt_ff;
      glide_on_in  = glide_on_ff;
      neg_in       = neg_ff;
      acc_in       = acc_ff;

      gcnt = {1'b0, glide_cnt_ff} + 1'b1;
      sus  = (sustain_ff > adsr_pkg::FULL_SCALE) ? adsr_pkg::FULL_SCALE : sustain_ff;
      up   = {1'b0, env_ff} + {1'b0, attack_ff};
      dn   = '0;
      move = {2'b00, div_q};
      if (neg_ff) begin
         move = (LW+1)'(-{2'b00, div_q});
      end
      fsum = (LW+1)'({2'b00, freq_now_ff}) + move;
      ssum = acc_ff + SW'(unsigned'(mul_p[SW-1:0])) + SW'(32768);

      case (state_ff)
         adsr_pkg::S_IDLE: begin
            if (req_valid) begin
               if (req_trigger) begin
                  gate_cnt_in  = req_gate_samples;
                  gate_open_in = 1'b1;
                  glide_cnt_in = '0;
                  freq_goal_in = req_target_freq;
                  if (req_glide_request && stage_ff != adsr_pkg::STG_IDLE) begin
                     glide_on_in = 1'b1;
                  end else begin
                     freq_now_in = req_target_freq;
                     glide_on_in = 1'b0;
                     env_in      = '0;
                     stage_in    = adsr_pkg::STG_ATTACK;
                  end
               end
               if (gate_open_in) begin
                  if (gate_cnt_in <= adsr_pkg::GATE_W'(1)) begin
                     gate_cnt_in  = '0;
                     gate_open_in = 1'b0;
                     stage_in     = adsr_pkg::STG_RELEASE;
                  end else begin
                     gate_cnt_in = gate_cnt_in - 1'b1;
                  end
               end
               state_in = adsr_pkg::S_GLIDE;
            end
         end
         adsr_pkg::S_GLIDE: begin
            if (!glide_on_ff) begin
               state_in = adsr_pkg::S_ENV;
            end else if (gcnt >= {1'b0, glen_ff} ||
                         gcnt[adsr_pkg::GLEN_W-1:0] == '0) begin
               freq_now_in  = freq_goal_ff;
               glide_on_in  = 1'b0;
               glide_cnt_in = '0;
               state_in     = adsr_pkg::S_ENV;
            end else begin
               glide_cnt_in = gcnt[adsr_pkg::GLEN_W-1:0];
               state_in     = adsr_pkg::S_GMUL;
            end
         end
         adsr_pkg::S_GMUL: begin
            state_in = adsr_pkg::S_GDIVS;
         end
         adsr_pkg::S_GDIVS: begin
            neg_in   = mul_p[PW-1];
            state_in = adsr_pkg::S_GDIV;
         end
         adsr_pkg::S_GDIV: begin
            if (div_done) begin
               freq_now_in = fsum[FW-1:0];
               state_in    = adsr_pkg::S_ENV;
            end
         end
         adsr_pkg::S_ENV: begin
            case (stage_ff)
               adsr_pkg::STG_ATTACK: begin
                  if (up >= {1'b0, adsr_pkg::FULL_SCALE}) begin
                     env_in   = adsr_pkg::FULL_SCALE;
                     stage_in = adsr_pkg::STG_DECAY;
                  end else begin
                     env_in = up[LW-1:0];
                  end
               end
               adsr_pkg::STG_DECAY: begin
                  dn = signed'({2'b00, env_ff}) - signed'({2'b00, decay_ff});
                  if (dn <= signed'({2'b00, sus})) begin
                     env_in   = sus;
                     stage_in = adsr_pkg::STG_SUSTAIN;
                  end else begin
                     env_in = dn[LW-1:0];
                  end
               end
               adsr_pkg::STG_SUSTAIN: begin
                  env_in = sus;
               end
               adsr_pkg::STG_RELEASE: begin
                  dn = signed'({2'b00, env_ff}) - signed'({2'b00, release_ff});
                  if (dn <= 0) begin
                     env_in   = '0;
                     stage_in = adsr_pkg::STG_IDLE;
                  end else begin
                     env_in = dn[LW-1:0];
                  end
               end
               default: begin
                  stage_in = adsr_pkg::STG_IDLE;
               end
            endcase
            state_in = adsr_pkg::S_SM1;
         end
         adsr_pkg::S_SM1: begin
            state_in = adsr_pkg::S_SM2;
         end
         adsr_pkg::S_SM2: begin
            acc_in   = SW'(unsigned'(mul_p[SW-1:0]));
            state_in = adsr_pkg::S_DONE;
         end
         adsr_pkg::S_DONE: begin
            // second smoother term lands here; commit once the response is free
            if (rsp_load) begin
               if (stage_ff != adsr_pkg::STG_IDLE) begin
                  smooth_in = ssum[adsr_pkg::COEF_W +: LW];
               end
               state_in = adsr_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = adsr_pkg::S_IDLE;
         end
      endcase
   end

   // the product register is overwritten every clock, so keep the final sum while stalled
   logic [SW-1:0] ssum_hold_ff, ssum_hold_in;
   logic          hold_ok_ff, hold_ok_in;
   logic [SW-1:0] ssum_now;

   assign ssum_now     = acc_ff + SW'(unsigned'(mul_p[SW-1:0])) + SW'(32768);
   assign ssum_hold_in = hold_ok_ff ? ssum_hold_ff : ssum_now;
   assign hold_ok_in   = (state_ff == adsr_pkg::S_DONE) && !rsp_load;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      neg_ff       <= neg_in;
      ssum_hold_ff <= ssum_hold_in;
      if (rsp_load) begin
         rsp_env_ff    <= env_ff;
         rsp_smooth_ff <= (stage_ff != adsr_pkg::STG_IDLE) ?
                          ssum_hold_in[adsr_pkg::COEF_W +: LW] : smooth_ff;
         rsp_freq_ff   <= freq_now_ff;
         rsp_stage_ff  <= stage_ff;
      end
      if (reset) begin
         state_ff     <= adsr_pkg::S_IDLE;
         stage_ff     <= adsr_pkg::STG_IDLE;
         env_ff       <= '0;
         smooth_ff    <= '0;
         gate_cnt_ff  <= '0;
         gate_open_ff <= 1'b0;
         freq_now_ff  <= adsr_pkg::RESET_FREQ;
         freq_goal_ff <= adsr_pkg::RESET_FREQ;
         glide_cnt_ff <= '0;
         glide_on_ff  <= 1'b0;
         hold_ok_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stage_ff     <= stage_in;
         env_ff       <= env_in;
         smooth_ff    <= (rsp_load && stage_ff != adsr_pkg::STG_IDLE) ?
                         ssum_hold_in[adsr_pkg::COEF_W +: LW] : smooth_in;
         gate_cnt_ff  <= gate_cnt_in;
         gate_open_ff <= gate_open_in;
         freq_now_ff  <= freq_now_in;
         freq_goal_ff <= freq_goal_in;
         glide_cnt_ff <= glide_cnt_in;
         glide_on_ff  <= glide_on_in;
         hold_ok_ff   <= hold_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_ff  <= adsr_pkg::RST_ATTACK;
         decay_ff   <= adsr_pkg::RST_DECAY;
         sustain_ff <= adsr_pkg::RST_SUSTAIN;
         release_ff <= adsr_pkg::RST_RELEASE;
         coeff_ff   <= adsr_pkg::RST_COEFF;
         glen_ff    <= adsr_pkg::RST_GLEN;
      end else if (csr_we) begin
         case (csr_addr)
            adsr_pkg::CSR_ATTACK:  attack_ff  <= csr_wdata;
            adsr_pkg::CSR_DECAY:   decay_ff   <= csr_wdata;
            adsr_pkg::CSR_SUSTAIN: sustain_ff <= csr_wdata;
            adsr_pkg::CSR_RELEASE: release_ff <= csr_wdata;
            adsr_pkg::CSR_COEFF:   coeff_ff   <= csr_wdata[adsr_pkg::COEF_W-1:0];
            adsr_pkg::CSR_GLEN:    glen_ff    <= csr_wdata[adsr_pkg::GLEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_envelope       = rsp_env_ff;
   assign rsp_smoothed_level = rsp_smooth_ff;
   assign rsp_current_freq   = rsp_freq_ff;
   assign rsp_stage          = rsp_stage_ff;

endmodule
`default_nettype wire
